// ----- design/bbsc_pkg.sv -----
// Shared types, constants and helpers for the BBS keystream cipher core.
// No dependencies; used by bbsc_sqmod and bbs_keystream_xor_cipher_core.
package bbsc_pkg;

  localparam int MOD_W         = 32;               // generator / modulus width
  localparam int MAX_STEP_BITS = 8;                // keystream bits per squaring, max
  localparam int CNT_W         = $clog2(MOD_W);    // bit counter of the serial unit
  localparam int MSG_W         = 8;
  localparam int LEN_W         = 4;
  localparam int BPS_W         = 4;
  localparam int REG_IDX_W     = 1;

  localparam logic [REG_IDX_W-1:0] REG_MODULUS       = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_BITS_PER_STEP = 1'd1;

  localparam logic [MOD_W-1:0] MODULUS_RST = MOD_W'(77);
  localparam logic [BPS_W-1:0] BPS_RST     = BPS_W'(3);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_CHUNK = 1'b1;

  // status of the serial square-mod unit
  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

  // effective chunk length: min(max(clen,1), max(bps,1), MAX_STEP_BITS)
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] clen,
                                               input logic [BPS_W-1:0] bps);
    logic [LEN_W-1:0] h;
    logic [LEN_W-1:0] l;
    h = LEN_W'(bps);
    if (h == '0) h = LEN_W'(1);
    if (h > LEN_W'(MAX_STEP_BITS)) h = LEN_W'(MAX_STEP_BITS);
    l = clen;
    if (l == '0) l = LEN_W'(1);
    if (l > h) l = h;
    return l;
  endfunction

  // low len bits set
  function automatic logic [MSG_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [MSG_W-1:0] m;
    m = '0;
    for (int i = 0; i < MSG_W; i++) begin
      m[i] = (LEN_W'(i) < len);
    end
    return m;
  endfunction

endpackage

// ----- design/bbsc_sqmod.sv -----
// Bit-serial x^2 mod n: optional reduction of x, then interleaved square.
// Depends on bbsc_pkg.
module bbsc_sqmod (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bbsc_pkg::MOD_W-1:0] x,
  input  logic [bbsc_pkg::MOD_W-1:0] n,
  output bbsc_pkg::sq_stat_t       stat,
  output logic [bbsc_pkg::MOD_W-1:0] result
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_RED  = 3'b010,
    PH_SQR  = 3'b100
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [bbsc_pkg::MOD_W-1:0]     a_r, a_nxt;     // multiplicand, reduced
  logic [bbsc_pkg::MOD_W-1:0]     sh_r, sh_nxt;   // bits consumed MSB first
  logic [bbsc_pkg::MOD_W-1:0]     acc_r, acc_nxt;
  logic [bbsc_pkg::MOD_W-1:0]     res_r, res_nxt;
  logic [bbsc_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           done_r, done_nxt;

  logic [bbsc_pkg::MOD_W-1:0]     addend;
  logic [bbsc_pkg::MOD_W+1:0]     t, d1, d2;
  logic [bbsc_pkg::MOD_W-1:0]     step;
  logic                           last_bit;

  // acc = 2*acc + addend, then up to two conditional subtracts of n
  always_comb begin
    if (phase_r == PH_RED) begin
      addend = {{(bbsc_pkg::MOD_W-1){1'b0}}, sh_r[bbsc_pkg::MOD_W-1]};
    end else begin
      addend = sh_r[bbsc_pkg::MOD_W-1] ? a_r : '0;
    end
    t  = {1'b0, acc_r, 1'b0} + {2'b00, addend};
    d1 = t - {2'b00, n};
    d2 = t - {1'b0, n, 1'b0};
    if (n == '0) begin
      step = t[bbsc_pkg::MOD_W-1:0];          // zero modulus: plain truncation
    end else if (!d2[bbsc_pkg::MOD_W+1]) begin
      step = d2[bbsc_pkg::MOD_W-1:0];
    end else if (!d1[bbsc_pkg::MOD_W+1]) begin
      step = d1[bbsc_pkg::MOD_W-1:0];
    end else begin
      step = t[bbsc_pkg::MOD_W-1:0];
    end
  end

  assign last_bit = (cnt_r == bbsc_pkg::CNT_W'(bbsc_pkg::MOD_W - 1));

  always_comb begin
    phase_nxt = phase_r;
    a_nxt     = a_r;
    sh_nxt    = sh_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          a_nxt   = x;
          sh_nxt  = x;
          acc_nxt = '0;
          cnt_nxt = '0;
          // unreduced input (such as a raw seed) needs x mod n first
          phase_nxt = ((n != '0) && (x >= n)) ? PH_RED : PH_SQR;
        end
      end
      PH_RED: begin
        acc_nxt = step;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r + bbsc_pkg::CNT_W'(1);
        if (last_bit) begin
          a_nxt     = step;
          sh_nxt    = step;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_SQR;
        end
      end
      PH_SQR: begin
        acc_nxt = step;
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r + bbsc_pkg::CNT_W'(1);
        if (last_bit) begin
          res_nxt   = step;
          done_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign stat.busy = (phase_r != PH_IDLE);
  assign stat.done = done_r;
  assign result    = res_r;

endmodule

// ----- design/bbs_keystream_xor_cipher_core.sv -----
// Top level of the BBS keystream XOR cipher (Blum-Goldwasser encryption side).
// Path: a chunk passes the bit-serial squaring, then the output stage; a last chunk
//   adds a second squaring; squaring a value >= N (such as a raw seed) adds a reduction pass.
// Throughput: one item at a time; a chunk or a squaring load must finish in the serial unit
//   before the next item is taken, a plain load every cycle.
// Reset: rst_n synchronous active low; modulus 77, bits_per_step 3, value 0.
module bbs_keystream_xor_cipher_core (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // seed_value[31:0], square_seed[32],
                                  // message_bits[40:33], chunk_len[44:41], zero pad
  input  logic        in_tuser,   // req_type: 0 load seed, 1 message chunk
  input  logic        in_tlast,   // last_chunk
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // cipher_bits[7:0], cipher_len[11:8],
                                  // final_state[43:12], zero pad
  output logic        out_tlast,  // is_last
  // configuration
  input  logic        cfg_we,
  input  logic [bbsc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_wdata
);

  // control flow: one item in flight; the output register frees the input side
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,   // ready for an item
    ST_LOAD = 5'b00010,   // squaring seed
    ST_SQ1  = 5'b00100,   // keystream squaring
    ST_SQ2  = 5'b01000,   // extra squaring for final state
    ST_PUSH = 5'b10000    // waiting for the output register
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [bbsc_pkg::MOD_W-1:0] modulus_r, modulus_nxt;
  logic [bbsc_pkg::BPS_W-1:0] bps_r, bps_nxt;

  // generator state
  logic [bbsc_pkg::MOD_W-1:0] gen_r, gen_nxt;

  // per-item payload
  logic [bbsc_pkg::MSG_W-1:0] msg_r, msg_nxt;
  logic [bbsc_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                       last_r, last_nxt;
  logic [bbsc_pkg::MSG_W-1:0] ks_r, ks_nxt;
  logic [bbsc_pkg::MOD_W-1:0] fin_r, fin_nxt;

  // output register
  logic                       ov_r, ov_nxt;
  logic [bbsc_pkg::MSG_W-1:0] o_cipher_r, o_cipher_nxt;
  logic [bbsc_pkg::LEN_W-1:0] o_len_r, o_len_nxt;
  logic                       o_last_r, o_last_nxt;
  logic [bbsc_pkg::MOD_W-1:0] o_fin_r, o_fin_nxt;

  // input fields
  logic                       f_req;
  logic [bbsc_pkg::MOD_W-1:0] f_seed;
  logic                       f_sq;
  logic [bbsc_pkg::MSG_W-1:0] f_msg;
  logic [bbsc_pkg::LEN_W-1:0] f_clen;

  logic                       in_acc;
  logic                       out_free;

  // square-mod unit hookup
  logic                       sq_start;
  logic [bbsc_pkg::MOD_W-1:0] sq_x;
  logic [bbsc_pkg::MOD_W-1:0] sq_res;
  bbsc_pkg::sq_stat_t         sq_stat;

  assign f_seed = in_tdata[31:0];
  assign f_sq   = in_tdata[32];
  assign f_msg  = in_tdata[40:33];
  assign f_clen = in_tdata[44:41];
  assign f_req  = in_tuser;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !ov_r || out_tready;

  bbsc_sqmod u_sqmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .x      (sq_x),
    .n      (modulus_r),
    .stat   (sq_stat),
    .result (sq_res)
  );

  // config writes must arrive only while idle; the block itself does not enforce this
  always_comb begin
    modulus_nxt = modulus_r;
    bps_nxt     = bps_r;
    if (cfg_we) begin
      case (cfg_index)
        bbsc_pkg::REG_MODULUS:       modulus_nxt = cfg_wdata;
        bbsc_pkg::REG_BITS_PER_STEP: bps_nxt     = cfg_wdata[bbsc_pkg::BPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    gen_nxt      = gen_r;
    msg_nxt      = msg_r;
    len_nxt      = len_r;
    last_nxt     = last_r;
    ks_nxt       = ks_r;
    fin_nxt      = fin_r;
    ov_nxt       = ov_r && !out_tready;
    o_cipher_nxt = o_cipher_r;
    o_len_nxt    = o_len_r;
    o_last_nxt   = o_last_r;
    o_fin_nxt    = o_fin_r;
    sq_start     = 1'b0;
    sq_x         = sq_res;   // second squaring chains off the first result
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (f_req == bbsc_pkg::REQ_LOAD) begin
            if (f_sq) begin
              sq_start  = 1'b1;
              sq_x      = f_seed;
              state_nxt = ST_LOAD;
            end else begin
              gen_nxt = f_seed;   // may stay above N until the next squaring
            end
          end else begin
            msg_nxt   = f_msg;
            len_nxt   = bbsc_pkg::eff_len(f_clen, bps_r);
            last_nxt  = in_tlast;
            sq_start  = 1'b1;
            sq_x      = gen_r;
            state_nxt = ST_SQ1;
          end
        end
      end
      ST_LOAD: begin
        if (sq_stat.done) begin
          gen_nxt   = sq_res;
          state_nxt = ST_IDLE;
        end
      end
      ST_SQ1: begin
        if (sq_stat.done) begin
          gen_nxt = sq_res;
          ks_nxt  = sq_res[bbsc_pkg::MSG_W-1:0];
          fin_nxt = '0;
          if (last_r) begin
            sq_start  = 1'b1;
            state_nxt = ST_SQ2;
          end else begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_SQ2: begin
        if (sq_stat.done) begin
          gen_nxt   = sq_res;
          fin_nxt   = sq_res;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          o_cipher_nxt = (msg_r ^ ks_r) & bbsc_pkg::len_mask(len_r);
          o_len_nxt    = len_r;
          o_last_nxt   = last_r;
          o_fin_nxt    = fin_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      modulus_r <= bbsc_pkg::MODULUS_RST;
      bps_r     <= bbsc_pkg::BPS_RST;
      gen_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      modulus_r <= modulus_nxt;
      bps_r     <= bps_nxt;
      gen_r     <= gen_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r      <= msg_nxt;
    len_r      <= len_nxt;
    last_r     <= last_nxt;
    ks_r       <= ks_nxt;
    fin_r      <= fin_nxt;
    o_cipher_r <= o_cipher_nxt;
    o_len_r    <= o_len_nxt;
    o_last_r   <= o_last_nxt;
    o_fin_r    <= o_fin_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'b0000, o_fin_r, o_len_r, o_cipher_r};

`ifndef SYNTHESIS
  // the serial unit is never busy while an item can be accepted
  a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sq_stat.busy)
    else $error("square unit busy while accepting items");

  // a finished squaring lands only in a state that waits for it
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |-> (state_r == ST_LOAD || state_r == ST_SQ1 || state_r == ST_SQ2))
    else $error("unexpected square-mod completion");

  // squaring results are fully reduced for a nonzero modulus
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_stat.done && modulus_r != '0) |-> (sq_res < modulus_r))
    else $error("square-mod result not reduced");

  // final_state is zero on results that are not last
  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[43:12] == '0))
    else $error("final_state set on a non-last result");
`endif

endmodule
